[src/efdc_pkg.sv]
// Shared codes, register indexes and reset values for the escaped frame deframer.
package efdc_pkg;

  localparam int unsigned WordBytes = 8;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] cfg_idx_t;

  // Control bytes of the line code
  localparam byte_t CODE_DLE = 8'h10;
  localparam byte_t CODE_ESC = 8'h1B;
  localparam byte_t CODE_STX = 8'h02;
  localparam byte_t CODE_ETX = 8'h03;

  // Register indexes
  localparam cfg_idx_t CFG_CHECKSUM_ENABLE   = 3'd0;
  localparam cfg_idx_t CFG_BINARY_START_CODE = 3'd1;
  localparam cfg_idx_t CFG_BINARY_END_CODE   = 3'd2;
  localparam cfg_idx_t CFG_RECEIVE_COMMAND   = 3'd3;

  // Register reset values
  localparam logic  RST_CHECKSUM_ENABLE   = 1'b1;
  localparam byte_t RST_BINARY_START_CODE = 8'd1;
  localparam byte_t RST_BINARY_END_CODE   = 8'd10;
  localparam byte_t RST_RECEIVE_COMMAND   = 8'd147;

endpackage

[src/efdc_if.sv]
// Stream interfaces for received bytes and emitted frame words.
interface efdc_rx_if;
  logic                 valid;
  logic                 ready;
  efdc_pkg::byte_t      rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efdc_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;
  logic [3:0]  byte_count;
  logic        last_word;

  modport source (output valid, output frame_word, output byte_count, output last_word,
                  input ready);
  modport sink   (input valid, input frame_word, input byte_count, input last_word,
                  output ready);
endinterface

[src/escaped_frame_deframer_checksum.sv]
// Top level: DLE/ESC byte-stuffed frame deframer with sum-8 check and word drain.
// Intake: one byte per cycle while idle; decoded and written to the frame store at accept.
// Drain after a passing close: per stored byte a store read and lane load, then each word
//   goes to the output register, held while the sink stalls; rx is held off until done.
// Reset (rst_ni low, async): registers to defaults, no frame open, no word pending; the
//   store is not cleared, only entries of the current frame are ever read.
module escaped_frame_deframer_checksum #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  efdc_pkg::cfg_idx_t      cfg_idx_i,
  input  efdc_pkg::byte_t         cfg_data_i,
  efdc_rx_if.sink                 rx_i,
  efdc_word_if.source             word_o
);

  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LW = $clog2(efdc_pkg::WordBytes);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LATCH,
    S_PUSH
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic            cs_en_q;
  efdc_pkg::byte_t start_code_q, end_code_q, rcv_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_en_q      <= efdc_pkg::RST_CHECKSUM_ENABLE;
      start_code_q <= efdc_pkg::RST_BINARY_START_CODE;
      end_code_q   <= efdc_pkg::RST_BINARY_END_CODE;
      rcv_cmd_q    <= efdc_pkg::RST_RECEIVE_COMMAND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        efdc_pkg::CFG_CHECKSUM_ENABLE:   cs_en_q      <= cfg_data_i[0];
        efdc_pkg::CFG_BINARY_START_CODE: start_code_q <= cfg_data_i;
        efdc_pkg::CFG_BINARY_END_CODE:   end_code_q   <= cfg_data_i;
        efdc_pkg::CFG_RECEIVE_COMMAND:   rcv_cmd_q    <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame tracking state
  // ---------------------------------------------------------------------------
  state_e          state_q;
  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [CW-1:0]   fill_q, fill_d;
  efdc_pkg::byte_t sum_q, sum_d;
  logic            ovf_q, ovf_d;
  efdc_pkg::byte_t first_q, first_d;

  // Drain sequencer
  logic [CW-1:0]   len_q;
  logic [CW-1:0]   rd_ptr_q;
  logic [LW-1:0]   lane_q;
  logic [3:0]      cnt_q;
  logic [63:0]     word_q;

  // Output register
  logic            out_valid_q;
  logic [63:0]     out_word_q;
  logic [3:0]      out_cnt_q;
  logic            out_last_q;

  // Frame store
  efdc_pkg::byte_t frame_store_q [MAX_FRAME_BYTES];
  efdc_pkg::byte_t rdata_q;

  logic            rx_fire;
  efdc_pkg::byte_t ch;
  logic            is_esc_byte;
  logic            store, clr, close, pass, wr_en;
  logic            rd_en;
  logic            out_free;
  logic            push_word;
  logic            read_done;

  assign rx_i.ready  = (state_q == S_IDLE);
  assign rx_fire     = rx_i.valid && rx_i.ready;
  assign ch          = rx_i.rx_byte;
  assign is_esc_byte = (ch == efdc_pkg::CODE_DLE) || (ch == efdc_pkg::CODE_ESC);

  // Escape decode: tests run in priority order, first match wins.
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    ovf_d      = ovf_q;
    first_d    = first_q;
    store      = 1'b0;
    clr        = 1'b0;
    close      = 1'b0;
    wr_en      = 1'b0;
    if (rx_fire) begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (ch == efdc_pkg::CODE_STX && !in_frame_q) begin
          in_frame_d = 1'b1;
          clr        = 1'b1;
        end else if (ch == efdc_pkg::CODE_ETX && in_frame_q) begin
          close = 1'b1;
        end else if (ch == start_code_q && !in_frame_q) begin
          in_frame_d = 1'b1;
          clr        = 1'b1;
        end else if (ch == end_code_q && in_frame_q) begin
          close = 1'b1;
        end else if (is_esc_byte && in_frame_q) begin
          store = 1'b1;
        end else begin
          // abort, or stray escape outside a frame
          in_frame_d = 1'b0;
          clr        = 1'b1;
        end
      end else if (is_esc_byte) begin
        esc_d = 1'b1;
      end else if (in_frame_q) begin
        store = 1'b1;
      end
    end

    if (store) begin
      if (fill_q < CW'(MAX_FRAME_BYTES)) begin
        wr_en  = 1'b1;
        fill_d = fill_q + CW'(1);
        sum_d  = sum_q + ch;
        if (fill_q == '0) begin
          first_d = ch;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (clr || close) begin
      fill_d = '0;
      sum_d  = '0;
      ovf_d  = 1'b0;
    end
    if (close) begin
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
    end
  end

  // Close verdict from the state before the closing byte
  assign pass = (fill_q != '0) && !ovf_q && (!cs_en_q || (sum_q == '0)) &&
                (first_q == rcv_cmd_q);

  assign rd_en     = (state_q == S_READ);
  assign out_free  = !out_valid_q || word_o.ready;
  assign push_word = (state_q == S_PUSH) && out_free;
  assign read_done = (rd_ptr_q + CW'(1)) == len_q;

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_store_q[fill_q[AW-1:0]] <= ch;
    end
    if (rd_en) begin
      rdata_q <= frame_store_q[rd_ptr_q[AW-1:0]];
    end
  end

  // State, sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      fill_q      <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      first_q     <= '0;
      len_q       <= '0;
      rd_ptr_q    <= '0;
      lane_q      <= '0;
      cnt_q       <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      fill_q     <= fill_d;
      sum_q      <= sum_d;
      ovf_q      <= ovf_d;
      first_q    <= first_d;

      // word taken and no new word loaded behind it
      if (out_valid_q && word_o.ready && !push_word) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (close && pass) begin
            len_q    <= fill_q;
            rd_ptr_q <= '0;
            lane_q   <= '0;
            cnt_q    <= '0;
            word_q   <= '0;
            state_q  <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_LATCH;
        end
        S_LATCH: begin
          word_q[{lane_q, 3'b000} +: 8] <= rdata_q;
          cnt_q    <= cnt_q + 4'd1;
          rd_ptr_q <= rd_ptr_q + CW'(1);
          lane_q   <= lane_q + LW'(1);
          if (lane_q == LW'(efdc_pkg::WordBytes - 1) || read_done) begin
            state_q <= S_PUSH;
          end else begin
            state_q <= S_READ;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_word_q  <= word_q;
            out_cnt_q   <= cnt_q;
            out_last_q  <= (rd_ptr_q == len_q);
            word_q      <= '0;
            cnt_q       <= '0;
            state_q     <= (rd_ptr_q == len_q) ? S_IDLE : S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign word_o.valid      = out_valid_q;
  assign word_o.frame_word = out_word_q;
  assign word_o.byte_count = out_cnt_q;
  assign word_o.last_word  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pass_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && close && pass) |=> (state_q == S_READ))
    else $error("passing close did not start drain");

  a_full_unless_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_cnt_q == 4'd8))
    else $error("short word that is not the last");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_cnt_q != 4'd0) && (out_cnt_q <= 4'd8)))
    else $error("word byte count out of range");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= CW'(MAX_FRAME_BYTES)) && ((state_q == S_IDLE) || (rd_ptr_q <= len_q)))
    else $error("fill count or read pointer past its bound");

endmodule

[dv/testbench.sv]
// Testbench for the escaped frame deframer: directed table, random framed traffic, checking.
`timescale 1ns / 1ps

module testbench;
  import efdc_pkg::*;

  localparam int unsigned MaxFrame = 256;
  // Wait bound for the longest drain, with margin
  localparam int DrainCycles = 2 * MaxFrame + 64;
  // Random requests per phase (small frames); with the table and the full-size
  // frame, about 480 over the run
  localparam int PhaseItems = 40;
  // Index above the register file; the block must ignore writes to it
  localparam cfg_idx_t CFG_UNUSED_IDX = 3'd5;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } frame_word_t;

  // One row of the directed table; has_word marks a typed-in expected word
  typedef struct packed {
    byte_t       rx_byte;
    logic        has_word;
    frame_word_t word;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  cfg_idx_t cfg_idx_i = '0;
  byte_t    cfg_data_i = '0;

  efdc_rx_if   rx_bus ();
  efdc_word_if word_bus ();

  escaped_frame_deframer_checksum #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .rx_i      (rx_bus),
    .word_o    (word_bus)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Deframer predictor: own copy of registers and frame state
  // ---------------------------------------------------------------------------
  logic  sum_check_on = RST_CHECKSUM_ENABLE;
  byte_t start_code   = RST_BINARY_START_CODE;
  byte_t end_code     = RST_BINARY_END_CODE;
  byte_t command_byte = RST_RECEIVE_COMMAND;

  byte_t frame_bytes [MaxFrame];
  int    frame_fill    = 0;
  logic  frame_open    = 1'b0;
  logic  escape_seen   = 1'b0;
  byte_t frame_sum     = '0;
  logic  frame_overrun = 1'b0;

  // Words still owed by the block, oldest first
  frame_word_t pending_words [$];

  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void clear_frame();
    frame_fill = 0;
    frame_sum = '0;
    frame_overrun = 1'b0;
  endfunction

  // Bytes past the store depth are dropped and poison the frame
  function automatic void keep_byte(input byte_t b);
    if (frame_fill < MaxFrame) begin
      frame_bytes[frame_fill] = b;
      frame_fill++;
      frame_sum = frame_sum + b;
    end else begin
      frame_overrun = 1'b1;
    end
  endfunction

  // Advance the deframer by one received byte; append any words the byte releases
  function automatic void deframe_byte(input byte_t b, ref frame_word_t words[$]);
    logic        closing;
    int          pos;
    int          n;
    frame_word_t w;
    closing = 1'b0;
    if (escape_seen) begin
      escape_seen = 1'b0;
      // First match wins: a code equal to DLE/ESC opens when idle, is data when open
      if (b == CODE_STX && !frame_open) begin
        frame_open = 1'b1;
        clear_frame();
      end else if (b == CODE_ETX && frame_open) begin
        closing = 1'b1;
      end else if (b == start_code && !frame_open) begin
        frame_open = 1'b1;
        clear_frame();
      end else if (b == end_code && frame_open) begin
        closing = 1'b1;
      end else if ((b == CODE_DLE || b == CODE_ESC) && frame_open) begin
        keep_byte(b);
      end else begin
        // abort inside a frame, no-op outside
        frame_open = 1'b0;
        clear_frame();
      end
    end else if (b == CODE_DLE || b == CODE_ESC) begin
      escape_seen = 1'b1;
    end else if (frame_open) begin
      keep_byte(b);
    end

    if (closing) begin
      if (frame_fill != 0 && !frame_overrun && (!sum_check_on || frame_sum == 8'h00) &&
          frame_bytes[0] == command_byte) begin
        pos = 0;
        while (pos < frame_fill) begin
          n = (frame_fill - pos > 8) ? 8 : frame_fill - pos;
          w = '0;
          for (int k = 0; k < n; k++) w.frame_word[8*k +: 8] = frame_bytes[pos + k];
          pos += n;
          w.byte_count = 4'(n);
          w.last_word = (pos >= frame_fill);
          words.insert(words.size(), w);
        end
      end
      frame_open = 1'b0;
      escape_seen = 1'b0;
      clear_frame();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Reset registers: sum check on, start 0x01, end 0x0A, cmd 0x93.
  // ---------------------------------------------------------------------------
  localparam stim_row_t DirectedRows [29] = '{
    // STX frame, byte extremes, sum 0x93+0xFF+0x00+0x6E wraps to zero
    '{CODE_DLE, 1'b0, '0},
    '{CODE_STX, 1'b0, '0},
    '{8'h93,    1'b0, '0},
    '{8'hFF,    1'b0, '0},
    '{8'h00,    1'b0, '0},
    '{8'h6E,    1'b0, '0},
    '{CODE_DLE, 1'b0, '0},
    '{CODE_ETX, 1'b1, '{64'h0000_0000_6E00_FF93, 4'd4, 1'b1}},
    // binary start/end codes, escaped DLE and ESC kept as data
    '{CODE_ESC, 1'b0, '0},
    '{8'h01,    1'b0, '0},
    '{8'h93,    1'b0, '0},
    '{CODE_DLE, 1'b0, '0},
    '{CODE_DLE, 1'b0, '0},
    '{CODE_ESC, 1'b0, '0},
    '{CODE_ESC, 1'b0, '0},
    '{8'h42,    1'b0, '0},
    '{CODE_ESC, 1'b0, '0},
    '{8'h0A,    1'b1, '{64'h0000_0000_421B_1093, 4'd4, 1'b1}},
    // empty frame: dropped
    '{CODE_DLE, 1'b0, '0},
    '{CODE_STX, 1'b0, '0},
    '{CODE_DLE, 1'b0, '0},
    '{CODE_ETX, 1'b0, '0},
    // stray escape outside a frame
    '{CODE_DLE, 1'b0, '0},
    '{8'h55,    1'b0, '0},
    // bad escape inside a frame aborts it
    '{CODE_DLE, 1'b0, '0},
    '{CODE_STX, 1'b0, '0},
    '{8'h93,    1'b0, '0},
    '{CODE_DLE, 1'b0, '0},
    '{8'h77,    1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Request driver. Called at a falling edge; returns at the falling edge after
  // the byte is taken. Typed rows supply their own expected word.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input byte_t b, input logic typed, input frame_word_t typed_word);
    frame_word_t got [$];
    while ($urandom_range(99) < send_idle_pct) begin
      rx_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    rx_bus.valid = 1'b1;
    rx_bus.rx_byte = b;
    do @(posedge clk_i); while (rx_bus.ready !== 1'b1);
    deframe_byte(b, got);
    if (typed) pending_words.insert(pending_words.size(), typed_word);
    else foreach (got[i]) pending_words.insert(pending_words.size(), got[i]);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Escaped frame with random content; most are well formed and pass the command and sum checks.
  // clean frames always carry the command byte, a fixing sum byte and a close.
  task automatic gen_frame(input int len, input logic clean);
    byte_t seq [$];
    byte_t b;
    byte_t sum;
    logic  fix_sum;
    sum = '0;
    fix_sum = clean || ($urandom_range(99) < 80);
    seq.insert(seq.size(), $urandom_range(1) ? CODE_DLE : CODE_ESC);
    seq.insert(seq.size(), $urandom_range(1) ? CODE_STX : start_code);
    for (int i = 0; i < len; i++) begin
      if (i == 0 && (clean || $urandom_range(99) < 85)) begin
        b = command_byte;
      end else if (fix_sum && i == len - 1) begin
        b = 8'h00 - sum;
      end else if ($urandom_range(9) == 0) begin
        // control-like values land inside frames often
        case ($urandom_range(5))
          0: b = CODE_DLE;
          1: b = CODE_ESC;
          2: b = CODE_STX;
          3: b = CODE_ETX;
          4: b = start_code;
          default: b = end_code;
        endcase
      end else begin
        b = 8'($urandom_range(255));
      end
      sum = sum + b;
      // byte stuffing for data equal to an escape
      if (b == CODE_DLE || b == CODE_ESC) begin
        seq.insert(seq.size(), $urandom_range(1) ? CODE_DLE : CODE_ESC);
      end
      seq.insert(seq.size(), b);
    end
    seq.insert(seq.size(), $urandom_range(1) ? CODE_DLE : CODE_ESC);
    if (!clean && $urandom_range(99) < 5) seq.insert(seq.size(), 8'($urandom_range(255)));
    else seq.insert(seq.size(), $urandom_range(1) ? CODE_ETX : end_code);
    foreach (seq[i]) send_byte(seq[i], 1'b0, '0);
  endtask

  // Register writes at falling edges; the predictor copy keeps the written width only
  task automatic program_regs(input byte_t cs, input byte_t st, input byte_t en,
                              input byte_t cmd);
    cfg_idx_t idx [5];
    byte_t    val [5];
    idx = '{CFG_CHECKSUM_ENABLE, CFG_BINARY_START_CODE, CFG_BINARY_END_CODE,
            CFG_RECEIVE_COMMAND, CFG_UNUSED_IDX};
    val = '{cs, st, en, cmd, 8'($urandom_range(255))};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i = 1'b1;
      cfg_idx_i = idx[i];
      cfg_data_i = val[i];
      case (idx[i])
        CFG_CHECKSUM_ENABLE:   sum_check_on = val[i][0];
        CFG_BINARY_START_CODE: start_code = val[i];
        CFG_BINARY_END_CODE:   end_code = val[i];
        CFG_RECEIVE_COMMAND:   command_byte = val[i];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  // Drop valid, let every owed word out, then cover the longest possible drain
  task automatic wait_idle();
    rx_bus.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Word sink: random stalls, ready changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    word_bus.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Scoreboard: each taken word against the oldest owed word
  always @(posedge clk_i) begin : check_words
    frame_word_t want;
    if (rst_ni && word_bus.valid === 1'b1 && word_bus.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: frame_word %h byte_count %0d last_word %b",
               word_bus.frame_word, word_bus.byte_count, word_bus.last_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (word_bus.frame_word !== want.frame_word) begin
          $error("frame_word: expected %h, got %h", want.frame_word, word_bus.frame_word);
          errors++;
        end
        if (word_bus.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, word_bus.byte_count);
          errors++;
        end
        if (word_bus.last_word !== want.last_word) begin
          $error("last_word: expected %b, got %b", want.last_word, word_bus.last_word);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: four phases, each with its own register setting and idling
  //   0: reset registers, no idling; directed table, random frames, the largest
  //      frame (exactly full, 32 words)
  //   1: sum check off, start 0xFF, end 0x00, cmd 0x00; sender idles often
  //   2: start = DLE, end = ESC, cmd 0xFF; receiver stalls often
  //   3: random codes and command; light idling on both sides
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int phase_start;
    rx_bus.valid = 1'b0;
    rx_bus.rx_byte = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          // upper bits of the enable write must be dropped
          program_regs(8'hFE, 8'hFF, 8'h00, 8'h00);
          send_idle_pct = 68;
          recv_stall_pct = 0;
        end
        2: begin
          program_regs(8'hFF, CODE_DLE, CODE_ESC, 8'hFF);
          send_idle_pct = 0;
          recv_stall_pct = 68;
        end
        default: begin
          program_regs(8'h01, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
          send_idle_pct = 6;
          recv_stall_pct = 6;
        end
      endcase

      if (ph == 0) begin
        foreach (DirectedRows[i]) begin
          send_byte(DirectedRows[i].rx_byte, DirectedRows[i].has_word, DirectedRows[i].word);
        end
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        // line noise between frames: loose bytes and stray escapes
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 4)) begin
            send_byte($urandom_range(3) == 0 ? CODE_DLE : 8'($urandom_range(255)), 1'b0, '0);
          end
        end
        case ($urandom_range(19))
          0:       gen_frame(0, 1'b0);
          1, 2, 3: gen_frame(8 * $urandom_range(1, 3), 1'b0);
          4, 5, 6, 7, 8, 9, 10, 11: gen_frame($urandom_range(1, 8), 1'b0);
          default: gen_frame($urandom_range(9, 40), 1'b0);
        endcase
      end

      if (ph == 0) begin
        gen_frame(MaxFrame, 1'b1);
      end

      wait_idle();
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[files.f]
src/efdc_pkg.sv
src/efdc_if.sv
src/escaped_frame_deframer_checksum.sv
dv/testbench.sv
